### hdl/sva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_pkg : shared types and constants for the four-lane vector ALU
// Request and result structs, operation codes and IEEE single constants.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int LANE_COUNT = 4;

  typedef enum logic [2:0] {
    FUNC_FADD    = 3'd0,
    FUNC_FSUB    = 3'd1,
    FUNC_FMUL    = 3'd2,
    FUNC_IADD    = 3'd3,
    FUNC_SHUFFLE = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
    logic [31:0] b0;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] b3;
    logic [7:0]  shuffle_mask;
  } req_t;

  typedef struct packed {
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
  } res_t;

  localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
  localparam logic [31:0] QUIET_BIT   = 32'h00400000;
  localparam logic [1:0]  SEL_MASK    = 2'h3;

  // Lane-level control carried down the lane pipeline
  typedef struct packed {
    logic       valid;
    logic [2:0] func;
  } lane_ctl_t;

endpackage

### hdl/sva_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_lane : one float/int lane, three register stages
// Stage 1 aligns or multiplies, stage 2 normalises, stage 3 rounds and packs.
// ----------------------------------------------------------------------------
module sva_lane (
  input  logic                    clk,
  input  logic                    rst,
  input  sva_pkg::lane_ctl_t      ctl_in,
  input  logic [31:0]             a,
  input  logic [31:0]             b,
  output logic [31:0]             r
);
  import sva_pkg::*;

  // ---- stage 0: classify, swap, align (combinational) ----
  logic [31:0] bx;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [31:0] big, sml;
  logic [7:0]  eb_big, eb_sml;
  logic [7:0]  ediff;
  logic [23:0] sig_big, sig_sml;
  logic [55:0] aln_big, aln_sml_full;
  logic [55:0] aln_sml;
  logic        sticky;
  logic        is_mul;
  logic        s_special;
  logic [31:0] special_val;
  logic [8:0]  ea_m, eb_m;
  logic [23:0] ma, mb;
  logic [47:0] prod;

  always_comb begin
    is_mul = (ctl_in.func == FUNC_FMUL);
    bx     = (ctl_in.func == FUNC_FSUB) ? {~b[31], b[30:0]} : b;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf  = (a[30:0] == 31'h7F800000);
    b_inf  = (b[30:0] == 31'h7F800000);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    if (a[30:0] < bx[30:0]) begin
      big = bx; sml = a;
    end else begin
      big = a;  sml = bx;
    end
    eb_big  = (big[30:23] == '0) ? 8'd1 : big[30:23];
    eb_sml  = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    sig_big = {(big[30:23] != '0), big[22:0]};
    sig_sml = {(sml[30:23] != '0), sml[22:0]};
    ediff   = eb_big - eb_sml;
    aln_big = {2'b0, sig_big, 30'b0};
    aln_sml_full = {2'b0, sig_sml, 30'b0};
    if (ediff >= 8'd56) begin
      aln_sml = {55'b0, (sig_sml != '0)};
      sticky  = 1'b0;
    end else begin
      aln_sml = aln_sml_full >> ediff;
      sticky  = ((aln_sml_full & ((56'd1 << ediff) - 56'd1)) != '0);
      aln_sml[0] = aln_sml[0] | sticky;
    end
    ea_m = {1'b0, (a[30:23] == '0) ? 8'd1 : a[30:23]};
    eb_m = {1'b0, (b[30:23] == '0) ? 8'd1 : b[30:23]};
    // full 48-bit significand product
    ma   = {(a[30:23] != '0), a[22:0]};
    mb   = {(b[30:23] != '0), b[22:0]};
    prod = {24'b0, ma} * {24'b0, mb};
    // specials
    s_special   = 1'b0;
    special_val = '0;
    if (a_nan || b_nan) begin
      s_special   = 1'b1;
      special_val = a_nan ? (a | QUIET_BIT) : (b | QUIET_BIT);
    end else if (is_mul) begin
      if (a_inf || b_inf) begin
        s_special   = 1'b1;
        special_val = (a_zero || b_zero) ? DEFAULT_NAN
                                         : {a[31] ^ b[31], 31'h7F800000};
      end else if (a_zero || b_zero) begin
        s_special   = 1'b1;
        special_val = {a[31] ^ b[31], 31'b0};
      end
    end else begin
      if (a_inf) begin
        s_special   = 1'b1;
        special_val = (b_inf && (a[31] != bx[31])) ? DEFAULT_NAN : a;
      end else if (b_inf) begin
        s_special   = 1'b1;
        special_val = bx;
      end else if (a_zero && b_zero) begin
        s_special   = 1'b1;
        special_val = {a[31] & bx[31], 31'b0};
      end
    end
  end

  // ---- stage 1 registers: sum or product ----
  lane_ctl_t   ctl1;
  logic        spec1;
  logic [31:0] sval1, ires1;
  logic        sign1;
  logic signed [10:0] exp1;  // value = sig * 2^(exp1 - 150)
  logic [55:0] sig1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl_in;
    end
    spec1 <= s_special;
    sval1 <= special_val;
    ires1 <= a + b;
    if (is_mul) begin
      sign1 <= a[31] ^ b[31];
      exp1  <= $signed({2'b0, ea_m}) + $signed({2'b0, eb_m}) - 11'sd150;
      sig1  <= {8'b0, prod};
    end else begin
      sign1 <= big[31];
      exp1  <= $signed({3'b0, eb_big}) - 11'sd30;
      sig1  <= (big[31] == sml[31]) ? aln_big + aln_sml : aln_big - aln_sml;
    end
  end

  // ---- stage 1->2: leading one and normalising shift amount ----
  logic [5:0] lead;
  logic signed [11:0] ex_c;
  logic [7:0] sh_r;     // right shift to leave 24 bits, incl denormal shift
  always_comb begin
    lead = '0;
    for (int i = 0; i < 56; i++) begin
      if (sig1[i]) lead = 6'(i);
    end
    ex_c = 12'(exp1) + $signed(12'(lead)) - 12'sd23;
    sh_r = 8'(lead) - 8'd23;
    if (ex_c < 12'sd1) begin
      sh_r = sh_r + 8'(12'sd1 - ex_c);
      ex_c = 12'sd1;
    end
  end

  // shift amount may be "negative" (left shift) when lead < 23
  logic        left1;
  logic [4:0]  lsh;
  always_comb begin
    left1 = (lead < 6'd23) && !((12'(exp1) + $signed(12'(lead)) - 12'sd23) < 12'sd1);
    lsh   = 5'(6'd23 - lead);
  end

  // ---- stage 2 registers: shifted mantissa with round bits ----
  lane_ctl_t   ctl2;
  logic        spec2, zero2, sign2;
  logic [31:0] sval2, ires2;
  logic [24:0] m2;      // 24 kept bits + spare
  logic        rnd_up2;
  logic signed [11:0] ex2;
  logic [63:0] rem, half, shv;
  logic [6:0]  shc;

  always_comb begin
    shc = (sh_r > 8'd63) ? 7'd63 : 7'(sh_r);
    shv = 64'(sig1) >> shc;
    if (shc == 7'd0) begin
      rem  = '0;
      half = '1;
    end else begin
      rem  = 64'(sig1) & ((64'd1 << shc) - 64'd1);
      half = 64'd1 << (shc - 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else begin
      ctl2 <= ctl1;
    end
    spec2 <= spec1;
    sval2 <= sval1;
    ires2 <= ires1;
    sign2 <= sign1;
    zero2 <= (sig1 == '0);
    ex2   <= ex_c;
    if (left1) begin
      m2      <= 25'(sig1[23:0] << lsh);
      rnd_up2 <= 1'b0;
    end else if (sh_r >= 8'd63) begin
      m2      <= '0;
      rnd_up2 <= 1'b0;
    end else begin
      m2      <= 25'(shv);
      rnd_up2 <= (shc != 7'd0) && ((rem > half) || ((rem == half) && shv[0]));
    end
  end

  // ---- stage 3: round and pack ----
  logic [24:0] m3;
  logic signed [11:0] ex3;
  logic [31:0] fres;
  always_comb begin
    m3  = m2 + 25'(rnd_up2);
    ex3 = ex2;
    if (m3[24]) begin
      m3  = m3 >> 1;
      ex3 = ex3 + 12'sd1;
    end
    if (zero2)
      fres = '0;
    else if (ex3 >= 12'sd255)
      fres = {sign2, 31'h7F800000};
    else
      fres = {sign2, (m3[23] ? 8'(ex3) : 8'd0), m3[22:0]};
  end

  always_ff @(posedge clk) begin
    unique case (ctl2.func)
      FUNC_FADD, FUNC_FSUB, FUNC_FMUL: r <= spec2 ? sval2 : fres;
      FUNC_IADD:                       r <= ires2;
      default:                         r <= '0;
    endcase
  end

endmodule

### hdl/sva_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_merge : combines lane results with the shuffle path
// Delays the shuffle result to match the lanes and drives the result strobe.
// ----------------------------------------------------------------------------
module sva_merge #(
  parameter int DEPTH = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  sva_pkg::req_t      req,
  input  logic [31:0]        l0,
  input  logic [31:0]        l1,
  input  logic [31:0]        l2,
  input  logic [31:0]        l3,
  output logic               done,
  output sva_pkg::res_t      res
);
  import sva_pkg::*;

  logic [31:0] src [4];
  res_t        shuf;
  res_t        sh_pipe [DEPTH];
  logic        is_sh   [DEPTH];
  logic        vld     [DEPTH];

  // shuffle: each lane picks a source lane of a
  always_comb begin
    src[0] = req.a0; src[1] = req.a1; src[2] = req.a2; src[3] = req.a3;
    shuf.r0 = src[req.shuffle_mask[1:0] & SEL_MASK];
    shuf.r1 = src[req.shuffle_mask[3:2] & SEL_MASK];
    shuf.r2 = src[req.shuffle_mask[5:4] & SEL_MASK];
    shuf.r3 = src[req.shuffle_mask[7:6] & SEL_MASK];
  end

  // delay line matched to lane latency
  always_ff @(posedge clk) begin
    sh_pipe[0] <= shuf;
    is_sh[0]   <= (req.func == FUNC_SHUFFLE);
    for (int i = 1; i < DEPTH; i++) begin
      sh_pipe[i] <= sh_pipe[i-1];
      is_sh[i]   <= is_sh[i-1];
    end
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) vld[i] <= 1'b0;
      done <= 1'b0;
    end else begin
      vld[0] <= start;
      for (int i = 1; i < DEPTH; i++) vld[i] <= vld[i-1];
      done <= vld[DEPTH-1];
    end
  end

  // merge: shuffle result or lane results
  always_ff @(posedge clk) begin
    if (is_sh[DEPTH-1]) res <= sh_pipe[DEPTH-1];
    else                res <= '{r0: l0, r1: l1, r2: l2, r3: l3};
  end

endmodule

### hdl/simd4_vector_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simd4_vector_alu_top : four-lane vector ALU
// Float add/sub/mul, integer add and lane shuffle on four 32-bit lanes.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on each rising edge with start high; busy is always
//   low, so a new request may be issued every cycle.
//   Request fields travel in req (sva_pkg::req_t), results in res
//   (sva_pkg::res_t), marked by done for exactly one cycle.
//   Each result passes through three lane stages (align or multiply,
//   normalise, round) plus the merge register. Throughput is one
//   request per cycle.
//   Reset clears the valid pipeline; no result is shown after reset until
//   a request has been taken. The receiver cannot stall, so no storage
//   beyond the pipeline is needed.
// ----------------------------------------------------------------------------
module simd4_vector_alu_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sva_pkg::req_t     req,
  output logic              done,
  output sva_pkg::res_t     res
);
  import sva_pkg::*;

  logic [31:0] av [LANE_COUNT];
  logic [31:0] bv [LANE_COUNT];
  logic [31:0] lr [LANE_COUNT];
  lane_ctl_t   ctl;

  assign busy = 1'b0;
  assign ctl  = '{valid: start, func: req.func};
  assign av[0] = req.a0; assign av[1] = req.a1;
  assign av[2] = req.a2; assign av[3] = req.a3;
  assign bv[0] = req.b0; assign bv[1] = req.b1;
  assign bv[2] = req.b2; assign bv[3] = req.b3;

  // lane array
  for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
    sva_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl),
      .a      (av[g]),
      .b      (bv[g]),
      .r      (lr[g])
    );
  end

  sva_merge #(.DEPTH(3)) u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .l0    (lr[0]),
    .l1    (lr[1]),
    .l2    (lr[2]),
    .l3    (lr[3]),
    .done  (done),
    .res   (res)
  );

endmodule

### hdl/sva_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_checker : port-level checks for the vector ALU
// Latency, strobe and reset behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
module sva_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input sva_pkg::res_t res
);
  import sva_pkg::*;

  // every request yields a result on done
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done) else $error("missing result");

  // no result without an earlier request
  a_nospur: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4)) else $error("spurious result");

  // pipeline empty just after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !done) else $error("result after reset");

  // never refuses a request
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");

  // result lanes fully defined while the strobe is high
  a_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(res)) else $error("unknown result");

endmodule

bind simd4_vector_alu_top sva_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res)
);
